[hdl/msf_pkg.sv]
// Package: shared types and constants of the mean-shift window filter.
`timescale 1ns / 1ps
package msf_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned QUOT_BITS = 8;
  localparam int unsigned BIT_IDX_W = 3;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned PADDR_W   = 3;

  // Register indexes on the configuration port
  localparam logic REG_DISTANCE_LIMIT = 1'b0;
  localparam logic REG_ROUND_COUNT    = 1'b1;

  localparam logic [7:0] DISTANCE_LIMIT_RST = 8'd20;
  localparam logic [5:0] ROUND_COUNT_RST    = 6'd20;

  typedef struct packed {
    logic [7:0] blue_sample;
    logic [7:0] green_sample;
    logic [7:0] red_sample;
    logic       is_center;
    logic       last_sample;
  } pixel_t;

  typedef struct packed {
    logic [7:0] blue_result;
    logic [7:0] green_result;
    logic [7:0] red_result;
  } result_t;

  // Control word from the sequencer to each channel lane
  typedef struct packed {
    logic                 seed;
    logic                 clear;
    logic                 accum;
    logic                 div_en;
    logic                 div_last;
    logic [BIT_IDX_W-1:0] div_bit;
  } lane_ctl_t;

endpackage

[hdl/msf_store.sv]
// Window sample memory: one write port, one registered read port.
`timescale 1ns / 1ps
module msf_store #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/msf_lane.sv]
// Channel lane: range match, sum and count, bit-serial average, current value.
`timescale 1ns / 1ps
module msf_lane #(
  parameter int unsigned CNT_W = 8,
  parameter int unsigned SUM_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  msf_pkg::lane_ctl_t  ctl,
  input  logic [7:0]          in_sample,
  input  logic [7:0]          mem_sample,
  input  logic [7:0]          limit,
  output logic [7:0]          cur
);
  import msf_pkg::*;

  logic [SUM_W-1:0]           sum;
  logic [CNT_W-1:0]           cnt;
  logic [QUOT_BITS-1:0]       quot;
  logic [7:0]                 diff;
  logic                       hit;
  logic [SUM_W+QUOT_BITS-1:0] shifted;
  logic                       fits;
  logic [QUOT_BITS-1:0]       quot_next;

  always_comb begin
    diff      = (mem_sample >= cur) ? (mem_sample - cur) : (cur - mem_sample);
    hit       = (diff <= limit);
    shifted   = (SUM_W + QUOT_BITS)'(cnt) << ctl.div_bit;
    fits      = ({{QUOT_BITS{1'b0}}, sum} >= shifted);
    quot_next = {quot[QUOT_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (ctl.seed) begin
      cur <= in_sample;
    end else if (ctl.div_en && ctl.div_last && (cnt != '0)) begin
      cur <= quot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum  <= '0;
      cnt  <= '0;
      quot <= '0;
    end else if (ctl.accum) begin
      if (hit) begin
        sum <= sum + SUM_W'(mem_sample);
        cnt <= cnt + CNT_W'(1);
      end
    end else if (ctl.div_en) begin
      // restoring step: subtract the shifted count when it fits
      if (fits) begin
        sum <= sum - SUM_W'(shifted);
      end
      quot <= quot_next;
    end
  end

endmodule

[hdl/msf_merge.sv]
// Merge stage: gather the three lane values into one result word.
`timescale 1ns / 1ps
module msf_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              emit,
  input  logic [7:0]        blue_value,
  input  logic [7:0]        green_value,
  input  logic [7:0]        red_value,
  output msf_pkg::result_t  result,
  output logic              result_valid
);
  import msf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.blue_result  <= blue_value;
      result.green_result <= green_value;
      result.red_result   <= red_value;
    end
  end

endmodule

[hdl/meanshift_range_filter_window_top.sv]
// Top level: mean-shift range filter over one window of BGR pixels.
// A pixel without the last mark is loaded while busy stays low.
// After the last pixel, each round walks the N stored samples through the registered memory
// read, drains, then runs a bit-serial divide from the top quotient bit down, and the
// result word shows for one cycle as busy falls.
// Throughput is set by the single read port of the window memory walked once per round.
// Reset (rst, synchronous) empties the window, zeroes the lane values, loads limit 20, rounds 20.
`timescale 1ns / 1ps
module meanshift_range_filter_window_top #(
  parameter int unsigned MAX_SAMPLES = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  msf_pkg::pixel_t               pixel,
  output msf_pkg::result_t              result,
  output logic                          result_valid,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msf_pkg::PADDR_W-1:0]   paddr,
  input  logic [msf_pkg::APB_W-1:0]     pwdata,
  output logic [msf_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);
  import msf_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned SUM_W  = CNT_W + PIX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     stored_count;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_valid;
  logic [5:0]           round_idx;
  logic [BIT_IDX_W-1:0] div_bit;
  logic [7:0]           distance_limit;
  logic [5:0]           round_count;

  logic                 accept;
  logic                 store_wr;
  logic                 scan_end;
  logic                 cfg_wr;
  logic                 rd_en;
  logic [23:0]          rd_word;
  lane_ctl_t            ctl;
  logic [7:0]           blue_value;
  logic [7:0]           green_value;
  logic [7:0]           red_value;

  // Handshake: take a pixel word on start whenever the sequencer is idle
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  // Drop pixels past the store depth; their marks still act
  assign store_wr = accept && (stored_count < CNT_W'(MAX_SAMPLES));
  assign scan_end = (CNT_W'(rd_addr) == (stored_count - CNT_W'(1)));
  assign rd_en    = (state == S_SCAN);

  // Configuration port: zero-wait APB, register index on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_DISTANCE_LIMIT: prdata = APB_W'(distance_limit);
      REG_ROUND_COUNT:    prdata = APB_W'(round_count);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= DISTANCE_LIMIT_RST;
      round_count    <= ROUND_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DISTANCE_LIMIT: distance_limit <= pwdata[7:0];
        REG_ROUND_COUNT:    round_count    <= pwdata[5:0];
        default:            ;
      endcase
    end
  end

  // Lane control: clear on the first scan cycle, accumulate behind the
  // registered read, step the divider from the top quotient bit down
  always_comb begin
    ctl.seed     = accept && pixel.is_center;
    ctl.clear    = (state == S_SCAN) && (rd_addr == '0);
    ctl.accum    = rd_valid;
    ctl.div_en   = (state == S_DIV);
    ctl.div_last = (div_bit == '0);
    ctl.div_bit  = div_bit;
  end

  // Sequencer: load window, then per round scan, drain, divide, then emit the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      rd_addr      <= '0;
      rd_valid     <= 1'b0;
      round_idx    <= '0;
      div_bit      <= '0;
    end else begin
      rd_valid <= rd_en;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (store_wr) begin
              stored_count <= stored_count + CNT_W'(1);
            end
            if (pixel.last_sample) begin
              rd_addr   <= '0;
              round_idx <= '0;
              state     <= (round_count == '0) ? S_DONE : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_DRAIN;
          end else begin
            rd_addr <= rd_addr + ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          div_bit <= BIT_IDX_W'(QUOT_BITS - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_bit == '0) begin
            rd_addr   <= '0;
            round_idx <= round_idx + 6'd1;
            state     <= ((round_idx + 6'd1) == round_count) ? S_DONE : S_SCAN;
          end else begin
            div_bit <= div_bit - BIT_IDX_W'(1);
          end
        end
        S_DONE: begin
          // empty the window for the next one
          stored_count <= '0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  msf_store #(
    .DEPTH  (MAX_SAMPLES),
    .ADDR_W (ADDR_W),
    .DATA_W (24)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (stored_count[ADDR_W-1:0]),
    .wr_data ({pixel.red_sample, pixel.green_sample, pixel.blue_sample}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  msf_lane #(.CNT_W(CNT_W), .SUM_W(SUM_W)) u_lane_blue (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_sample  (pixel.blue_sample),
    .mem_sample (rd_word[7:0]),
    .limit      (distance_limit),
    .cur        (blue_value)
  );

  msf_lane #(.CNT_W(CNT_W), .SUM_W(SUM_W)) u_lane_green (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_sample  (pixel.green_sample),
    .mem_sample (rd_word[15:8]),
    .limit      (distance_limit),
    .cur        (green_value)
  );

  msf_lane #(.CNT_W(CNT_W), .SUM_W(SUM_W)) u_lane_red (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_sample  (pixel.red_sample),
    .mem_sample (rd_word[23:16]),
    .limit      (distance_limit),
    .cur        (red_value)
  );

  msf_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .emit         (state == S_DONE),
    .blue_value   (blue_value),
    .green_value  (green_value),
    .red_value    (red_value),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

[hdl/msf_checker.sv]
// Port-level checker for the mean-shift window filter, bound to the top level.
`timescale 1ns / 1ps
module msf_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  msf_pkg::pixel_t  pixel,
  input  logic             result_valid
);
  import msf_pkg::*;

  // one result word per window, never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // the last pixel always starts the rounds
  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && pixel.last_sample) |=> busy)
    else $error("last pixel did not start the rounds");

  // other pixels are loaded without the block going busy
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !pixel.last_sample) |=> !busy)
    else $error("block went busy on a non-final pixel");

  // the result appears exactly when the rounds finish
  a_result_at_finish: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid)
    else $error("rounds ended without a result");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without preceding rounds");

endmodule

bind meanshift_range_filter_window_top msf_checker u_msf_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .pixel        (pixel),
  .result_valid (result_valid)
);
